FILE: sv/rsd_pkg.sv
// Shared types and constants for the ring slider direction unit.
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

  // Width of one touch level and of the slide sums
  localparam int LEVEL_W = 16;

  typedef logic [LEVEL_W-1:0] level_t;

endpackage

`default_nettype wire

FILE: sv/rsd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/rsd_front.sv
// Front end: accepts positions, writes them to the level store, queues frame jobs.
`timescale 1ns / 1ps
`default_nettype none

module rsd_front #(
  parameter int MAX_POSITIONS = 16,
  localparam int IDX_W = $clog2(MAX_POSITIONS),
  localparam int CNT_W = $clog2(MAX_POSITIONS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  // Input queue side
  input  logic             push,
  output logic             full,
  input  logic             last_position,
  // Store write port
  output logic             mem_we,
  output logic [IDX_W:0]   mem_waddr,
  // Frame job queue toward the back end
  output logic             job_valid,
  output logic             job_bank,
  output logic [CNT_W-1:0] job_count,
  output logic             job_ovf,
  input  logic             job_pop
);

  import rsd_pkg::*;

  logic             bank;
  logic [CNT_W-1:0] pos_count;
  logic             ovf_seen;
  logic             room;
  logic             accept;
  logic             push_job;

  // Two-entry job queue, one entry per store bank
  logic             q_bank [2];
  logic [CNT_W-1:0] q_cnt  [2];
  logic             q_ovf  [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       q_used;

  assign room     = (pos_count < CNT_W'(MAX_POSITIONS));
  assign full     = (q_used == 2'd2);
  assign accept   = push && !full;
  assign push_job = accept && last_position;

  // Positions past capacity are dropped
  assign mem_we    = accept && room;
  assign mem_waddr = {bank, pos_count[IDX_W-1:0]};

  assign job_valid = (q_used != 2'd0);
  assign job_bank  = q_bank[rd_ptr];
  assign job_count = q_cnt[rd_ptr];
  assign job_ovf   = q_ovf[rd_ptr];

  // Frame bookkeeping and job queue
  always_ff @(posedge clk) begin
    if (rst) begin
      bank      <= 1'b0;
      pos_count <= '0;
      ovf_seen  <= 1'b0;
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      q_used    <= 2'd0;
    end else begin
      if (accept) begin
        if (last_position) begin
          pos_count <= '0;
          ovf_seen  <= 1'b0;
          bank      <= ~bank;
        end else if (room) begin
          pos_count <= pos_count + 1'b1;
        end else begin
          ovf_seen <= 1'b1;
        end
      end

      if (push_job) begin
        q_bank[wr_ptr] <= bank;
        q_cnt[wr_ptr]  <= room ? pos_count + 1'b1 : pos_count;
        q_ovf[wr_ptr]  <= ovf_seen | !room;
        wr_ptr         <= ~wr_ptr;
      end

      if (job_pop) begin
        rd_ptr <= ~rd_ptr;
      end

      case ({push_job, job_pop})
        2'b10:   q_used <= q_used + 2'd1;
        2'b01:   q_used <= q_used - 2'd1;
        default: q_used <= q_used;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/rsd_back.sv
// Back end: sweeps one stored frame, accumulates slide sums, holds the result.
`timescale 1ns / 1ps
`default_nettype none

module rsd_back #(
  parameter int MAX_POSITIONS = 16,
  localparam int IDX_W = $clog2(MAX_POSITIONS),
  localparam int CNT_W = $clog2(MAX_POSITIONS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  rsd_pkg::level_t  cancel,
  // Frame job from the front end
  input  logic             job_valid,
  input  logic             job_bank,
  input  logic [CNT_W-1:0] job_count,
  input  logic             job_ovf,
  output logic             job_pop,
  // Store read port
  output logic             rd_en,
  output logic [IDX_W:0]   rd_addr,
  input  rsd_pkg::level_t  rd_cur,
  input  rsd_pkg::level_t  rd_prv,
  // Result queue side
  output logic             empty,
  input  logic             pop,
  output rsd_pkg::level_t  slide_amount,
  output logic             right_slide,
  output logic             left_slide,
  output logic             frame_overflow
);

  import rsd_pkg::*;

  localparam int K_W = $clog2(MAX_POSITIONS + 2);

  typedef enum logic [1:0] {B_IDLE, B_SWEEP, B_DRAIN, B_FINISH} state_t;

  state_t         state;
  logic [K_W-1:0] k;
  logic [K_W-1:0] n_ext;
  logic [K_W-1:0] rd_idx;
  logic           sweep_end;

  // Read, window, term and accumulate stages
  logic       rd_v;
  logic       rd_last;
  logic [1:0] seen;
  logic       ev_v;
  logic       ev_last;
  logic       acc_v;
  logic       acc_last;
  level_t     win_cur [3];
  level_t     win_prv [3];
  level_t     add_l;
  level_t     add_r;
  level_t     left;
  level_t     right;

  // Output register
  logic   out_valid;
  level_t out_amount;
  logic   out_right;
  logic   out_left;
  logic   out_ovf;
  logic   out_free;

  // Combinational terms
  level_t p_c, p_p, c_c, c_p, x_c, x_p;
  level_t d_c_up, d_c_dn, d_p_up, d_p_dn, d_x_up, d_x_dn;
  logic   l1, r1, l2, r2;
  level_t add_l_next, add_r_next;
  level_t sum_l, sum_r, left_next, right_next;
  logic   r_gt, l_gt;
  level_t amount_next;

  assign n_ext     = K_W'(job_count);
  assign sweep_end = (k == n_ext + 1'b1);

  // Read order: last position, then 0 .. n-1, then position 0 again
  always_comb begin
    if (k == '0) begin
      rd_idx = n_ext - 1'b1;
    end else if (sweep_end) begin
      rd_idx = '0;
    end else begin
      rd_idx = k - 1'b1;
    end
  end

  assign rd_en   = (state == B_SWEEP);
  assign rd_addr = {job_bank, rd_idx[IDX_W-1:0]};

  // Change terms for the position in the middle of the window
  assign p_c = win_cur[2];
  assign p_p = win_prv[2];
  assign c_c = win_cur[1];
  assign c_p = win_prv[1];
  assign x_c = win_cur[0];
  assign x_p = win_prv[0];

  assign d_c_up = c_c - c_p;
  assign d_c_dn = c_p - c_c;
  assign d_p_up = p_c - p_p;
  assign d_p_dn = p_p - p_c;
  assign d_x_up = x_c - x_p;
  assign d_x_dn = x_p - x_c;

  assign l1 = (p_c > p_p) && (c_c < c_p);
  assign r1 = !l1 && (p_c < p_p) && (c_c > c_p);
  assign l2 = (x_c < x_p) && (c_c > c_p);
  assign r2 = !l2 && (x_c > x_p) && (c_c < c_p);

  assign add_l_next = (l1 ? d_c_dn + d_p_up : '0) + (l2 ? d_c_up + d_x_dn : '0);
  assign add_r_next = (r1 ? d_c_up + d_p_dn : '0) + (r2 ? d_c_dn + d_x_up : '0);

  // Accumulate with wrap, then cancel and floor at zero
  assign sum_l      = left + add_l;
  assign sum_r      = right + add_r;
  assign left_next  = (sum_l > cancel) ? sum_l - cancel : '0;
  assign right_next = (sum_r > cancel) ? sum_r - cancel : '0;

  // Direction and magnitude
  assign r_gt        = (right > left);
  assign l_gt        = (left > right);
  assign amount_next = r_gt ? right - left : (l_gt ? left - right : '0);

  assign out_free = !out_valid || pop;
  assign job_pop  = (state == B_FINISH) && out_free;

  assign empty          = !out_valid;
  assign slide_amount   = out_amount;
  assign right_slide    = out_right;
  assign left_slide     = out_left;
  assign frame_overflow = out_ovf;

  // Sweep sequencer, stage registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      k         <= '0;
      rd_v      <= 1'b0;
      rd_last   <= 1'b0;
      seen      <= 2'd0;
      ev_v      <= 1'b0;
      ev_last   <= 1'b0;
      acc_v     <= 1'b0;
      acc_last  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v    <= rd_en;
      rd_last <= rd_en && sweep_end;

      // Slide the three-position window on each read return
      ev_v    <= rd_v && (seen == 2'd2);
      ev_last <= rd_last;
      if (rd_v) begin
        win_cur[2] <= win_cur[1];
        win_prv[2] <= win_prv[1];
        win_cur[1] <= win_cur[0];
        win_prv[1] <= win_prv[0];
        win_cur[0] <= rd_cur;
        win_prv[0] <= rd_prv;
        if (seen != 2'd2) begin
          seen <= seen + 2'd1;
        end
      end

      acc_v    <= ev_v;
      acc_last <= ev_last;
      if (ev_v) begin
        add_l <= add_l_next;
        add_r <= add_r_next;
      end

      if (acc_v) begin
        left  <= left_next;
        right <= right_next;
      end

      // Result taken with no new one loading behind it
      if (pop && out_valid && !job_pop) begin
        out_valid <= 1'b0;
      end

      case (state)
        B_IDLE: begin
          if (job_valid) begin
            left  <= '0;
            right <= '0;
            seen  <= 2'd0;
            k     <= '0;
            state <= (job_count >= CNT_W'(2)) ? B_SWEEP : B_FINISH;
          end
        end
        B_SWEEP: begin
          k <= k + 1'b1;
          if (sweep_end) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (acc_v && acc_last) begin
            state <= B_FINISH;
          end
        end
        B_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_amount <= amount_next;
            out_right  <= r_gt;
            out_left   <= l_gt;
            out_ovf    <= job_ovf;
            state      <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_pop_has_job: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> job_valid)
    else $error("job popped from empty queue");

  a_dir_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_right && out_left))
    else $error("both slide directions set");

  a_amount_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_right && !out_left) |-> (out_amount == '0))
    else $error("nonzero amount without direction");

  a_acc_in_sweep: assert property (@(posedge clk) disable iff (rst)
    acc_v |-> (state == B_SWEEP || state == B_DRAIN))
    else $error("accumulate outside a sweep");

  a_sweep_job: assert property (@(posedge clk) disable iff (rst)
    (state == B_SWEEP) |-> job_valid)
    else $error("sweep without a pending job");
`endif

endmodule

`default_nettype wire

FILE: sv/ring_slider_direction_unit.sv
// Top level of the ring slider direction unit.
// A frame of n >= 2 positions is swept after its last position is taken;
// frames of fewer than two positions skip the sweep and give a zero result.
// One position per cycle goes into the store while the job queue is not full; the
// frame sweep reads n + 2 entries through each store's single read port.
// Two store banks let one frame load while the previous one is swept.
// Reset clears control state and cancel_value; the store is left unwritten.
`timescale 1ns / 1ps
`default_nettype none

module ring_slider_direction_unit #(
  parameter int MAX_POSITIONS = 16
) (
  input  logic            clk,
  input  logic            rst,
  // Input queue
  input  logic            push,
  output logic            full,
  input  rsd_pkg::level_t current_level,
  input  rsd_pkg::level_t previous_level,
  input  logic            last_position,
  // Result queue
  output logic            empty,
  input  logic            pop,
  output rsd_pkg::level_t slide_amount,
  output logic            right_slide,
  output logic            left_slide,
  output logic            frame_overflow,
  // Configuration
  input  logic            cancel_value_we,
  input  rsd_pkg::level_t cancel_value
);

  import rsd_pkg::*;

  localparam int IDX_W     = $clog2(MAX_POSITIONS);
  localparam int CNT_W     = $clog2(MAX_POSITIONS + 1);
  localparam int RAM_DEPTH = 2 * (2 ** IDX_W);

  level_t           cancel;
  logic             mem_we;
  logic [IDX_W:0]   mem_waddr;
  logic             rd_en;
  logic [IDX_W:0]   rd_addr;
  level_t           rd_cur;
  level_t           rd_prv;
  logic             job_valid;
  logic             job_bank;
  logic [CNT_W-1:0] job_count;
  logic             job_ovf;
  logic             job_pop;

  // Cancel register
  always_ff @(posedge clk) begin
    if (rst) begin
      cancel <= '0;
    end else if (cancel_value_we) begin
      cancel <= cancel_value;
    end
  end

  rsd_front #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .last_position(last_position),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .job_valid    (job_valid),
    .job_bank     (job_bank),
    .job_count    (job_count),
    .job_ovf      (job_ovf),
    .job_pop      (job_pop)
  );

  // Level stores, two banks each
  rsd_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(RAM_DEPTH)
  ) u_current_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(current_level),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_cur)
  );

  rsd_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(RAM_DEPTH)
  ) u_previous_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(previous_level),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_prv)
  );

  rsd_back #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cancel        (cancel),
    .job_valid     (job_valid),
    .job_bank      (job_bank),
    .job_count     (job_count),
    .job_ovf       (job_ovf),
    .job_pop       (job_pop),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_cur        (rd_cur),
    .rd_prv        (rd_prv),
    .empty         (empty),
    .pop           (pop),
    .slide_amount  (slide_amount),
    .right_slide   (right_slide),
    .left_slide    (left_slide),
    .frame_overflow(frame_overflow)
  );

endmodule

`default_nettype wire

FILE: test/slide_direction_checker.sv
// Checker for the ring slider direction unit: predicts each frame's slide result and compares.
`timescale 1ns / 1ps

module slide_direction_checker #(
  parameter int POSITIONS = 16
) (
  input  logic            clk,
  input  logic            rst,
  // Input queue
  input  logic            push,
  input  logic            full,
  input  rsd_pkg::level_t current_level,
  input  rsd_pkg::level_t previous_level,
  input  logic            last_position,
  // Result queue
  input  logic            empty,
  input  logic            pop,
  input  rsd_pkg::level_t slide_amount,
  input  logic            right_slide,
  input  logic            left_slide,
  input  logic            frame_overflow,
  // Configuration
  input  logic            cancel_value_we,
  input  rsd_pkg::level_t cancel_value,
  // Status to the testbench top
  output int              fail_count,
  output int              pending
);

  import rsd_pkg::*;

  typedef struct packed {
    level_t amount;
    logic   right;
    logic   left;
    logic   overflow;
  } slide_t;

  // Frame being collected and the active cancel setting
  level_t      cur_ring [POSITIONS];
  level_t      prev_ring[POSITIONS];
  int unsigned ring_fill;
  logic        ring_overflow;
  level_t      cancel_now;
  slide_t      slides_due[$];

  // Lower a sum by the cancel setting, never below zero
  function automatic level_t shave(level_t s);
    return (s > cancel_now) ? level_t'(s - cancel_now) : '0;
  endfunction

  // Sweep the stored ring and derive direction and amount
  function automatic slide_t sweep_ring();
    slide_t      r;
    level_t      lsum, rsum;
    int unsigned n, ip, ix, c, cc, p, pp, x, xx;
    r    = '0;
    lsum = '0;
    rsum = '0;
    n    = ring_fill;
    r.overflow = ring_overflow;
    if (n >= 2) begin
      for (int unsigned i = 0; i < n; i++) begin
        ip = (i == 0) ? n - 1 : i - 1;
        ix = (i + 1 == n) ? 0 : i + 1;
        c  = cur_ring[i];
        cc = prev_ring[i];
        p  = cur_ring[ip];
        pp = prev_ring[ip];
        x  = cur_ring[ix];
        xx = prev_ring[ix];
        // change against the counterclockwise neighbor
        if (p > pp && c < cc) lsum = level_t'(lsum + (cc - c) + (p - pp));
        else if (p < pp && c > cc) rsum = level_t'(rsum + (c - cc) + (pp - p));
        // change against the clockwise neighbor
        if (x < xx && c > cc) lsum = level_t'(lsum + (c - cc) + (xx - x));
        else if (x > xx && c < cc) rsum = level_t'(rsum + (cc - c) + (x - xx));
        lsum = shave(lsum);
        rsum = shave(rsum);
      end
      if (rsum > lsum) begin
        r.right  = 1'b1;
        r.amount = level_t'(rsum - lsum);
      end else if (lsum > rsum) begin
        r.left   = 1'b1;
        r.amount = level_t'(lsum - rsum);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    slide_t want;
    if (rst) begin
      ring_fill     = 0;
      ring_overflow = 1'b0;
      cancel_now    = '0;
      fail_count    = 0;
      slides_due.delete();
    end else begin
      // register write
      if (cancel_value_we) cancel_now = cancel_value;

      // result side
      if (pop && !empty) begin
        if (slides_due.size() == 0) begin
          $error("result item with no frame waiting for it");
          fail_count++;
        end else begin
          want = slides_due.pop_front();
          if (slide_amount !== want.amount) begin
            $error("slide_amount: expected %0d, got %0d", want.amount, slide_amount);
            fail_count++;
          end
          if (right_slide !== want.right) begin
            $error("right_slide: expected %0d, got %0d", want.right, right_slide);
            fail_count++;
          end
          if (left_slide !== want.left) begin
            $error("left_slide: expected %0d, got %0d", want.left, left_slide);
            fail_count++;
          end
          if (frame_overflow !== want.overflow) begin
            $error("frame_overflow: expected %0d, got %0d", want.overflow, frame_overflow);
            fail_count++;
          end
        end
      end

      // input side: store the position, evaluate on frame end
      if (push && !full) begin
        if (ring_fill < POSITIONS) begin
          cur_ring[ring_fill]  = current_level;
          prev_ring[ring_fill] = previous_level;
          ring_fill++;
        end else begin
          ring_overflow = 1'b1;
        end
        if (last_position) begin
          slides_due.push_back(sweep_ring());
          ring_fill     = 0;
          ring_overflow = 1'b0;
        end
      end
    end
    pending = slides_due.size();
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the ring slider direction unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;

  import rsd_pkg::*;

  localparam int POSITIONS   = 16;
  localparam int HOLD_CYCLES = 400;   // long receiver stall
  localparam int SETTLE      = 40;    // above the worst frame latency
  localparam int STUCK_LIMIT = 5000;  // cycles with no item moving
  localparam int PHASE_ITEMS = 66;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   push = 1'b0;
  logic   full;
  level_t current_level = '0;
  level_t previous_level = '0;
  logic   last_position = 1'b0;
  logic   empty;
  logic   pop = 1'b0;
  level_t slide_amount;
  logic   right_slide;
  logic   left_slide;
  logic   frame_overflow;
  logic   cancel_value_we = 1'b0;
  level_t cancel_value = '0;

  int fail_count;
  int pending;
  int hold_req = 0;
  int items_sent = 0;
  int burst_left = 0;
  int stuck = 0;

  ring_slider_direction_unit #(
    .MAX_POSITIONS(POSITIONS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .current_level  (current_level),
    .previous_level (previous_level),
    .last_position  (last_position),
    .empty          (empty),
    .pop            (pop),
    .slide_amount   (slide_amount),
    .right_slide    (right_slide),
    .left_slide     (left_slide),
    .frame_overflow (frame_overflow),
    .cancel_value_we(cancel_value_we),
    .cancel_value   (cancel_value)
  );

  slide_direction_checker #(
    .POSITIONS(POSITIONS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .current_level  (current_level),
    .previous_level (previous_level),
    .last_position  (last_position),
    .empty          (empty),
    .pop            (pop),
    .slide_amount   (slide_amount),
    .right_slide    (right_slide),
    .left_slide     (left_slide),
    .frame_overflow (frame_overflow),
    .cancel_value_we(cancel_value_we),
    .cancel_value   (cancel_value),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Receiver: changing pop patterns, plus the long hold on request
  initial begin
    int mode;
    int cnt;
    int holds_done;
    mode       = 0;
    cnt        = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req != holds_done) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        if (cnt % 64 == 0) mode = $urandom_range(0, 3);
        cnt++;
        case (mode)
          0: begin
            pop <= 1'b1;
          end
          1: begin
            pop <= 1'($urandom_range(0, 1));
          end
          2: begin
            pop <= ($urandom_range(0, 4) == 0);
          end
          default: begin
            pop <= (cnt % 7 < 3);
          end
        endcase
      end
    end
  end

  // Offer one position, in bursts with random gaps
  task automatic send_item(level_t cur, level_t prev, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    push           <= 1'b1;
    current_level  <= cur;
    previous_level <= prev;
    last_position  <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Stop offering until every frame result has come back
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic level_t extreme_level();
    case ($urandom_range(0, 6))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFE;
      3: return 16'hFFFF;
      4: return 16'h8000;
      5: return 16'h7FFF;
      default: return level_t'($urandom);
    endcase
  endfunction

  // Mostly small frames, some full and some past capacity
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 1;
    if (r < 78) return $urandom_range(2, 8);
    if (r < 90) return $urandom_range(9, POSITIONS);
    return $urandom_range(POSITIONS + 1, POSITIONS + 4);
  endfunction

  // Build one frame in a given flavor and send it
  task automatic send_frame(int n, int flavor);
    level_t    cur_v [POSITIONS + 4];
    level_t    prev_v[POSITIONS + 4];
    int signed v;
    int        k, step;
    level_t    base, amp;
    base = level_t'($urandom_range(0, 1000));
    amp  = level_t'($urandom_range(50, 3000));
    for (int i = 0; i < n; i++) begin
      case (flavor)
        0: begin
          cur_v[i]  = level_t'($urandom);
          prev_v[i] = level_t'($urandom);
        end
        1: begin
          // small changes, comparable to the cancel setting
          prev_v[i] = level_t'($urandom);
          v = int'(prev_v[i]) + $urandom_range(0, 600) - 300;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          cur_v[i] = level_t'(v);
        end
        2: begin
          cur_v[i]  = extreme_level();
          prev_v[i] = extreme_level();
        end
        default: begin
          prev_v[i] = base;
          cur_v[i]  = level_t'(base + $urandom_range(0, 20));
        end
      endcase
    end
    // moving bump: peak shifts one position either way round the ring
    if (flavor == 3) begin
      k    = $urandom_range(0, n - 1);
      step = $urandom_range(0, 1) ? 1 : n - 1;
      prev_v[k]              = prev_v[k] + amp;
      cur_v[(k + step) % n]  = cur_v[(k + step) % n] + amp;
    end
    for (int i = 0; i < n; i++) send_item(cur_v[i], prev_v[i], i == n - 1);
  endtask

  initial begin
    level_t cancel_set[6];
    int     phase_start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single position, two positions, extremes, overflow
    send_item(16'd1234, 16'd9, 1'b1);
    send_item(16'hFFFF, 16'h0000, 1'b0);
    send_item(16'h0000, 16'hFFFF, 1'b1);
    send_item(16'h0000, 16'hFFFF, 1'b0);
    send_item(16'hFFFF, 16'h0000, 1'b0);
    send_item(16'h8000, 16'h7FFF, 1'b1);
    for (int i = 0; i < POSITIONS + 2; i++) begin
      send_item(level_t'($urandom), level_t'($urandom), i == POSITIONS + 1);
    end
    drain();

    // Random phases, one cancel setting each
    cancel_set[0] = level_t'($urandom_range(1, 400));
    cancel_set[1] = 16'hFFFF;
    cancel_set[2] = level_t'($urandom);
    cancel_set[3] = 16'h0000;
    cancel_set[4] = 16'h0001;
    cancel_set[5] = level_t'($urandom_range(0, 255));
    for (int ph = 0; ph < 6; ph++) begin
      cancel_value_we <= 1'b1;
      cancel_value    <= cancel_set[ph];
      @(posedge clk);
      cancel_value_we <= 1'b0;
      phase_start = items_sent;
      // long receiver stall while short frames keep coming
      if (ph == 0) begin
        hold_req <= hold_req + 1;
        for (int f = 0; f < 30; f++) send_frame($urandom_range(1, 2), $urandom_range(0, 3));
      end
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_frame(pick_size(), $urandom_range(0, 3));
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rsd_pkg.sv
sv/rsd_ram.sv
sv/rsd_front.sv
sv/rsd_back.sv
sv/ring_slider_direction_unit.sv
test/slide_direction_checker.sv
test/tb_top.sv
